// ===== rtl/erai_pkg.sv =====
// Package for the Euler 3-2-1 angle rate integrator: fixed-point constants,
// the CORDIC arctangent table and saturation helpers. No dependencies.
`timescale 1ns / 1ps
package erai_pkg;

  localparam int unsigned DivNumW = 60;
  localparam int unsigned DivDenW = 33;

  localparam logic signed [39:0] PiQ30     = 40'sd3373259426;
  localparam logic signed [39:0] TwoPiQ30  = 40'sd6746518852;
  localparam logic signed [39:0] HalfPiQ30 = 40'sd1686629713;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  localparam logic [7:0] CfgTimeStep   = 8'd0;
  localparam logic [7:0] CfgCosPitchMin = 8'd1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_REDUCE = 7'b0000010,
    S_WRAP   = 7'b0000100,
    S_FOLD   = 7'b0001000,
    S_ROT    = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_DIV    = 7'b1000000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [39:0] atan_q30(input logic [4:0] k);
    logic [31:0] v;
    begin
      unique case (k)
        5'd0:  v = 32'h3243F6A8;
        5'd1:  v = 32'h1DAC6705;
        5'd2:  v = 32'h0FADBAFC;
        5'd3:  v = 32'h07F56EA6;
        5'd4:  v = 32'h03FEAB76;
        5'd5:  v = 32'h01FFD55B;
        5'd6:  v = 32'h00FFFAAA;
        5'd7:  v = 32'h007FFF55;
        5'd8:  v = 32'h003FFFEA;
        5'd9:  v = 32'h001FFFFD;
        5'd10: v = 32'h000FFFFF;
        5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF;
        5'd13: v = 32'h0001FFFF;
        5'd14: v = 32'h0000FFFF;
        5'd15: v = 32'h00007FFF;
        5'd16: v = 32'h00003FFF;
        5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF;
        5'd19: v = 32'h000007FF;
        5'd20: v = 32'h000003FF;
        5'd21: v = 32'h000001FF;
        5'd22: v = 32'h000000FF;
        5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F;
        5'd25: v = 32'h0000001F;
        5'd26: v = 32'h0000000F;
        5'd27: v = 32'h00000007;
        5'd28: v = 32'h00000003;
        5'd29: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      atan_q30 = $signed({8'd0, v});
    end
  endfunction

  // Clamp a wide rate to the signed 32-bit range.
  function automatic logic signed [31:0] clamp_rate(input logic signed [60:0] v);
    begin
      if (v > 61'sd2147483647) clamp_rate = 32'sh7FFFFFFF;
      else if (v < -61'sd2147483648) clamp_rate = 32'sh80000000;
      else clamp_rate = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat_angle(input logic signed [40:0] v);
    begin
      if (v > 41'sd2147483647) sat_angle = 32'sh7FFFFFFF;
      else if (v < -41'sd2147483648) sat_angle = 32'sh80000000;
      else sat_angle = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/erai_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on erai_pkg.
`timescale 1ns / 1ps
module erai_div import erai_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DivNumW-1:0]   num_i,
  input  logic signed [DivDenW-1:0]   den_i,
  output div_stat_t                   stat_o,
  output logic signed [DivNumW-1:0]   quot_o
);
  logic             busy_q, done_q, neg_q;
  logic [5:0]       cnt_q;
  logic [DivNumW-1:0] num_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   rem_q;
  logic [DivDenW:0]   shl;
  logic [DivDenW+1:0] trial;

  assign shl   = {rem_q[DivDenW-1:0], num_q[DivNumW-1]};
  assign trial = {1'b0, shl} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i[DivNumW-1] ? DivNumW'(-num_i) : num_i;
      den_q <= den_i[DivDenW-1] ? DivDenW'(-den_i) : den_i;
      neg_q <= num_i[DivNumW-1] ^ den_i[DivDenW-1];
      rem_q <= '0;
    end else if (busy_q) begin
      if (!trial[DivDenW+1]) begin
        rem_q <= trial[DivDenW:0];
        num_q <= {num_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_q <= shl;
        num_q <= {num_q[DivNumW-2:0], 1'b0};
      end
    end
  end

  assign quot_o = neg_q ? -$signed(num_q) : $signed(num_q);
  assign stat_o = '{busy: busy_q, done: done_q};
endmodule

// ===== rtl/euler_angle_rate_integrator_top.sv =====
// Euler 3-2-1 angle rate integrator, top level: sequencer, CORDIC, shared
// multiplier and angle stores. Depends on erai_pkg and erai_div.
`timescale 1ns / 1ps
//
// Channel   | Direction | Payload
// s_axis    | in        | tdata: rate_x[23:0], rate_y[47:24], rate_z[71:48]
// m_axis    | out       | tdata: roll[31:0], pitch[63:32], yaw[95:64]; tuser: singular
// cfg       | in        | index 0 time_step, index 1 cos_pitch_min
//
// One tick takes two CORDIC runs (five reduction steps, wrap, fold and the
// rotations), up to 13 sequencer steps around the shared 34x34 multiplier, and
// two passes of the serial divider when the pitch is not singular. A new
// transfer is accepted only once the sequencer is back in its idle state.
// The divider and the CORDIC loop take most of the time of a tick.
// Reset clears the angle stores and loads the register defaults.
// The result is held in an output register; the next tick is taken while it
// waits, and the sequencer stalls at the last step until the register frees.
module euler_angle_rate_integrator_top import erai_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // rate_x, rate_y, rate_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        m_axis_tuser,   // singular
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  // multiply/integrate step codes
  localparam logic [5:0] M_P1 = 6'd0, M_P2 = 6'd1, M_P3 = 6'd2, M_P4 = 6'd3,
                         M_B  = 6'd4, M_AST = 6'd5, M_DV0 = 6'd6, M_DV1 = 6'd7,
                         M_IP = 6'd8, M_IR = 6'd9, M_IY = 6'd10, M_IW = 6'd11,
                         M_END = 6'd12;

  state_e state_q, state_d;
  logic [5:0]  cnt_q;
  logic [31:0] time_step_q;
  logic [24:0] cos_min_q;
  logic signed [31:0] roll_q, pitch_q, yaw_q;
  logic signed [24:0] wx_q, wy_q, wz_q;
  logic        trig_sel_q, flip_q, neg_q, sing_q, div_sel_q;
  logic [37:0] mag_q;
  logic signed [39:0] z_q;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] sp_q, cp_q, st_q, ct_q;
  logic signed [67:0] prod_q, acc_q;
  logic signed [25:0] a16_q, b16_q;
  logic signed [59:0] q0_q, q1_q;
  logic        out_valid_q, out_sing_q;
  logic [95:0] out_data_q;

  logic               in_xfer, out_free, stall;
  logic signed [33:0] mul_a, mul_b;
  logic signed [39:0] red_k, wrap_r, fold_z;
  logic signed [33:0] xs, ys, x_n, y_n;
  logic signed [39:0] z_n;
  logic [4:0]         k;
  logic               rot_last;
  logic signed [68:0] sum_ab;
  logic [32:0]        act;
  logic               sing_c;
  logic               div_start;
  logic signed [59:0] div_num, div_quot;
  div_stat_t          div_stat;
  logic signed [40:0] upd;
  logic signed [31:0] next_ang;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign stall         = (state_q == S_MUL) && (cnt_q == M_END) && !out_free;

  always_comb begin
    red_k  = TwoPiQ30 <<< cnt_q[2:0];
    wrap_r = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
    if (z_q > HalfPiQ30) fold_z = PiQ30 - z_q;
    else if (z_q < -HalfPiQ30) fold_z = -PiQ30 - z_q;
    else fold_z = z_q;
  end

  // One CORDIC micro-rotation.
  assign k  = cnt_q[4:0];
  assign xs = x_q >>> k;
  assign ys = y_q >>> k;
  always_comb begin
    if (!z_q[39]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - atan_q30(k);
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + atan_q30(k);
    end
  end
  assign rot_last = (cnt_q == 6'(CORDIC_STEPS - 1));

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cnt_q)
      M_P1: begin mul_a = 34'(wy_q); mul_b = 34'(sp_q); end
      M_P2: begin mul_a = 34'(wz_q); mul_b = 34'(cp_q); end
      M_P3: begin mul_a = 34'(wy_q); mul_b = 34'(cp_q); end
      M_P4: begin mul_a = 34'(wz_q); mul_b = 34'(sp_q); end
      M_AST: begin mul_a = 34'(a16_q); mul_b = 34'(st_q); end
      M_IP: begin
        mul_a = 34'(b16_q);
        mul_b = $signed({2'b00, time_step_q});
      end
      M_IR: begin
        mul_a = 34'(clamp_rate(61'(wx_q) + 61'(q0_q)));
        mul_b = $signed({2'b00, time_step_q});
      end
      M_IY: begin
        mul_a = 34'(clamp_rate(61'(q1_q)));
        mul_b = $signed({2'b00, time_step_q});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sum_ab = 69'(acc_q) + 69'(prod_q);
  assign act    = ct_q[32] ? 33'(-ct_q) : ct_q;
  assign sing_c = (ct_q == '0) || ({1'b0, act} < {3'b000, cos_min_q, 6'd0});

  assign div_start = (state_q == S_MUL) && ((cnt_q == M_DV0) || (cnt_q == M_DV1));
  assign div_num   = (cnt_q == M_DV0) ? prod_q[59:0] : {{4{a16_q[25]}}, a16_q, 30'd0};

  erai_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (ct_q),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  // Angle update: old angle plus (rate * time_step) >> 24, saturated. The
  // product registered in the previous step belongs to the angle updated now.
  always_comb begin
    unique case (cnt_q)
      M_IR:    upd = 41'(pitch_q) + 41'($signed(prod_q[63:24]));
      M_IY:    upd = 41'(roll_q) + 41'($signed(prod_q[63:24]));
      default: upd = 41'(yaw_q) + 41'($signed(prod_q[63:24]));
    endcase
    next_ang = sat_angle(upd);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_REDUCE;
      S_REDUCE: if (cnt_q == '0) state_d = S_WRAP;
      S_WRAP:   state_d = S_FOLD;
      S_FOLD:   state_d = S_ROT;
      S_ROT:    if (rot_last) state_d = trig_sel_q ? S_MUL : S_REDUCE;
      S_MUL: begin
        if (div_start) state_d = S_DIV;
        else if (cnt_q == M_END && out_free) state_d = S_IDLE;
      end
      S_DIV:    if (div_stat.done) state_d = S_MUL;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      trig_sel_q  <= 1'b0;
      time_step_q <= 32'd5368709;
      cos_min_q   <= 25'd16777;
      roll_q      <= '0;
      pitch_q     <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgTimeStep:    time_step_q <= cfg_data_i;
          CfgCosPitchMin: cos_min_q   <= cfg_data_i[24:0];
          default: ;
        endcase
      end
      if (state_q == S_MUL && cnt_q == M_END && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          trig_sel_q <= 1'b0;
          cnt_q      <= 6'd4;
        end
        S_REDUCE: if (cnt_q != '0) cnt_q <= cnt_q - 6'd1;
        S_FOLD:   cnt_q <= '0;
        S_ROT: begin
          if (rot_last) begin
            trig_sel_q <= 1'b1;
            cnt_q      <= trig_sel_q ? M_P1 : 6'd4;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_MUL: begin
          if (cnt_q == M_IR) pitch_q <= next_ang;
          if (cnt_q == M_IY && !sing_q) roll_q <= next_ang;
          if (cnt_q == M_IW && !sing_q) yaw_q <= next_ang;
          if (cnt_q == M_AST && sing_q) begin
            cnt_q <= M_IP;
          end else if (cnt_q != M_END && !div_start) begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_DIV: if (div_stat.done) cnt_q <= cnt_q + 6'd1;
        default: ;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      wx_q <= 25'($signed(s_axis_tdata[23:0]));
      wz_q <= 25'($signed(s_axis_tdata[47:24]));
      wy_q <= -25'($signed(s_axis_tdata[71:48]));
    end
    if (state_q == S_IDLE || (state_q == S_ROT && rot_last && !trig_sel_q)) begin
      // Load the next angle to reduce (pitch after roll).
      if (state_q == S_IDLE) begin
        mag_q <= roll_q[31] ? 38'(-{roll_q, 6'd0}) : {roll_q, 6'd0};
        neg_q <= roll_q[31];
      end else begin
        mag_q <= pitch_q[31] ? 38'(-{pitch_q, 6'd0}) : {pitch_q, 6'd0};
        neg_q <= pitch_q[31];
      end
    end
    if (state_q == S_REDUCE && {2'b00, mag_q} >= red_k) mag_q <= 38'({2'b00, mag_q} - red_k);
    if (state_q == S_WRAP) begin
      if (wrap_r > PiQ30) z_q <= wrap_r - TwoPiQ30;
      else if (wrap_r < -PiQ30) z_q <= wrap_r + TwoPiQ30;
      else z_q <= wrap_r;
    end
    if (state_q == S_FOLD) begin
      z_q    <= fold_z;
      flip_q <= (z_q > HalfPiQ30) || (z_q < -HalfPiQ30);
      x_q    <= GainQ30;
      y_q    <= '0;
    end
    if (state_q == S_ROT) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
      if (rot_last) begin
        if (trig_sel_q) begin
          st_q <= y_n[32:0];
          ct_q <= flip_q ? 33'(-x_n) : x_n[32:0];
        end else begin
          sp_q <= y_n[32:0];
          cp_q <= flip_q ? 33'(-x_n) : x_n[32:0];
        end
      end
    end
    if (state_q == S_MUL && !stall) begin
      prod_q <= mul_a * mul_b;
      if (cnt_q == M_P2 || cnt_q == M_P4) acc_q <= prod_q;
      if (cnt_q == M_P3) a16_q <= sum_ab[55:30];
      if (cnt_q == M_B) begin
        b16_q  <= 26'((69'(acc_q) - 69'(prod_q)) >>> 30);
        sing_q <= sing_c;
      end
    end
    if (state_q == S_MUL && cnt_q == M_DV0) div_sel_q <= 1'b0;
    if (state_q == S_MUL && cnt_q == M_DV1) div_sel_q <= 1'b1;
    if (state_q == S_DIV && div_stat.done) begin
      if (div_sel_q) q1_q <= div_quot;
      else q0_q <= div_quot;
    end
    if (state_q == S_MUL && cnt_q == M_END && out_free) begin
      out_data_q <= {yaw_q, pitch_q, roll_q};
      out_sing_q <= sing_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sing_q;

`ifndef ASSERT_OFF
  // A singular tick must leave roll untouched.
  a_sing_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && cnt_q == M_IY && sing_q) |=> $stable(roll_q))
    else $error("roll changed on singular tick");
  // The divider is only started when idle.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
  // Folded CORDIC angle lies within plus or minus half pi.
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FOLD) |=> (z_q <= HalfPiQ30) && (z_q >= -HalfPiQ30))
    else $error("CORDIC angle out of range");
`endif
endmodule

// ===== test/tb_euler_angle_rate_integrator_top.sv =====
// Self-checking testbench for euler_angle_rate_integrator_top: drives gyro ticks and
// register writes, predicts the integrated roll, pitch and yaw, and checks each result.
// Depends on erai_pkg and the integrator RTL.
`timescale 1ns / 1ps

module tb_euler_angle_rate_integrator_top;
  import erai_pkg::*;

  localparam int unsigned CordicSteps = 24;
  localparam logic [7:0] CfgBadIndexA = 8'd2;
  localparam logic [7:0] CfgBadIndexB = 8'd255;
  localparam int unsigned IdleWait = 400;

  typedef struct packed {
    logic signed [31:0] yaw;
    logic signed [31:0] pitch;
    logic signed [31:0] roll;
    logic               singular;
  } attitude_t;

  // Attitude predictor and store of expected attitudes.
  class attitude_scoreboard;
    logic [31:0]        time_step;
    logic [24:0]        cos_pitch_min;
    logic signed [31:0] roll_q24, pitch_q24, yaw_q24;
    longint             atan_tab[32];
    attitude_t          expected_q[$];
    int                 failures;

    function new();
      atan_tab = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
        64'h0, 64'h0};
      time_step     = 32'd5368709;
      cos_pitch_min = 25'd16777;
      roll_q24 = '0; pitch_q24 = '0; yaw_q24 = '0;
      failures = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      if (idx == CfgTimeStep) time_step = data;
      else if (idx == CfgCosPitchMin) cos_pitch_min = data[24:0];
    endfunction

    // Sine and cosine in Q2.30 of a Q7.24 angle.
    function void sin_cos(input logic signed [31:0] ang, output longint s, output longint c);
      longint z, x, y, xs, ys;
      bit     flip;
      z = longint'(ang) * 64;
      x = longint'(GainQ30);
      y = 0;
      flip = 0;
      z = z % longint'(TwoPiQ30);
      if (z > longint'(PiQ30)) z -= longint'(TwoPiQ30);
      else if (z < -longint'(PiQ30)) z += longint'(TwoPiQ30);
      if (z > longint'(HalfPiQ30)) begin
        z = longint'(PiQ30) - z; flip = 1;
      end else if (z < -longint'(HalfPiQ30)) begin
        z = -longint'(PiQ30) - z; flip = 1;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        xs = x >>> (i % 32);
        ys = y >>> (i % 32);
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i % 32];
        end else begin
          x += ys; y -= xs; z += atan_tab[i % 32];
        end
      end
      s = y;
      c = flip ? -x : x;
    endfunction

    function logic signed [31:0] advance(logic signed [31:0] old, longint rate);
      longint r, d, sum;
      r = rate > 64'sd2147483647 ? 64'sd2147483647 :
          (rate < -64'sd2147483648 ? -64'sd2147483648 : rate);
      d = (r * longint'({32'd0, time_step})) >>> 24;
      sum = longint'(old) + d;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
    endfunction

    function void note_tick(logic [71:0] data);
      longint    wx, wy, wz, sp, cp, st, ct, a16, b16, act;
      logic signed [23:0] rx, ry, rz;
      bit        sing;
      attitude_t att;
      rx = data[23:0]; ry = data[47:24]; rz = data[71:48];
      wx = rx; wy = -longint'(rz); wz = ry;
      sin_cos(roll_q24, sp, cp);
      sin_cos(pitch_q24, st, ct);
      a16 = (wy * sp + wz * cp) >>> 30;
      b16 = (wy * cp - wz * sp) >>> 30;
      act = ct < 0 ? -ct : ct;
      sing = (ct == 0) || (act < longint'({39'd0, cos_pitch_min}) * 64);
      if (!sing) begin
        roll_q24 = advance(roll_q24, wx + (a16 * st) / ct);
        yaw_q24  = advance(yaw_q24, (a16 * (64'sd1 <<< 30)) / ct);
      end
      pitch_q24 = advance(pitch_q24, b16);
      att.roll = roll_q24; att.pitch = pitch_q24; att.yaw = yaw_q24;
      att.singular = sing;
      expected_q.push_back(att);
    endfunction

    function void check_result(logic [95:0] data, logic user);
      attitude_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected result %h singular %b", data, user);
        return;
      end
      want = expected_q.pop_front();
      if (data !== {want.yaw, want.pitch, want.roll} || user !== want.singular) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: roll %h/%h pitch %h/%h yaw %h/%h singular %b/%b (exp/got)",
                   want.roll, data[31:0], want.pitch, data[63:32], want.yaw, data[95:64],
                   want.singular, user);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i, cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  attitude_scoreboard attitude_sb;
  int unsigned burst_left;

  euler_angle_rate_integrator_top #(.CORDIC_STEPS(CordicSteps)) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("Verification failed");
    $finish;
  end

  // Receiver: stall on a random duty pattern that changes from phase to phase;
  // some stretches accept every cycle.
  initial begin
    int unsigned period, duty, phase_len, cyc;
    m_axis_tready = 1'b0;
    period = 1; duty = 1; phase_len = 0; cyc = 0;
    forever begin
      @(negedge clk_i);
      if (phase_len == 0) begin
        phase_len = $urandom_range(100, 600);
        period = $urandom_range(1, 12);
        duty = ($urandom_range(0, 3) == 0) ? period : $urandom_range(1, period);
      end
      phase_len--;
      cyc++;
      m_axis_tready = (cyc % period) < duty;
    end
  end

  // Check every result transfer at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      attitude_sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Send one tick; bursts of random length with random gaps between them.
  task automatic send_tick(logic signed [23:0] rx, logic signed [23:0] ry,
                           logic signed [23:0] rz);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {rz, ry, rx};
    do @(posedge clk_i); while (!s_axis_tready);
    attitude_sb.note_tick(s_axis_tdata);
    @(negedge clk_i);
    if (burst_left == 0) s_axis_tvalid = 1'b0;
  endtask

  // Wait until every expected attitude is back and the block has gone quiet.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (attitude_sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (IdleWait) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    attitude_sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random rate: mostly realistic magnitudes, sometimes full range or extremes.
  function automatic logic signed [23:0] pick_rate();
    case ($urandom_range(0, 9))
      0, 1:    return 24'($urandom());
      2:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      3, 4:    return 24'(int'($urandom_range(0, 4000000)) - 2000000);
      default: return 24'(int'($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  task automatic random_ticks(int n);
    for (int i = 0; i < n; i++) send_tick(pick_rate(), pick_rate(), pick_rate());
  endtask

  initial begin
    attitude_sb = new();
    burst_left = 0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (IdleWait) @(negedge clk_i);

    // Directed: field extremes at the default settings.
    send_tick('0, '0, '0);
    send_tick(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_tick(24'sh800000, 24'sh800000, 24'sh800000);
    send_tick(24'sh7FFFFF, 24'sh800000, 24'sh000001);
    send_tick(24'shFFFFFF, 24'sh000001, 24'sh800000);
    send_tick(24'sh010000, 24'shFF0000, 24'sh020000);
    drain();

    // Drive pitch to just short of vertical with a one-second step: singular,
    // roll and yaw held, then huge rates to saturate.
    write_reg(CfgTimeStep, 32'hFFFFFFFF);
    write_reg(CfgBadIndexA, 32'h12345678);
    send_tick(24'sh001000, 24'sh002000, -24'sd102943);
    send_tick(24'sh003000, 24'sh004000, 24'sh000000);
    send_tick(24'sh7FFFFF, 24'sh7FFFFF, 24'sh000010);
    send_tick(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    send_tick(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    send_tick(24'sh800000, 24'sh800000, 24'sh7FFFFF);
    drain();

    // Zero step: nothing moves. A bad register index changes nothing.
    write_reg(CfgTimeStep, 32'd0);
    write_reg(CfgBadIndexB, 32'hFFFFFFFF);
    send_tick(24'sh7FFFFF, 24'sh800000, 24'sh123456);
    send_tick(24'sh800000, 24'sh7FFFFF, 24'sh654321);
    drain();

    // Minimum above one: every tick singular. Then minimum zero.
    write_reg(CfgTimeStep, 32'd5368709);
    write_reg(CfgCosPitchMin, 32'h01FFFFFF);
    send_tick(24'sh050000, 24'shFB0000, 24'sh030000);
    send_tick(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    drain();
    write_reg(CfgCosPitchMin, 32'd0);
    send_tick(24'sh050000, 24'shFB0000, 24'sh030000);
    drain();

    // Random phases across register settings.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          write_reg(CfgTimeStep, 32'd5368709);
          write_reg(CfgCosPitchMin, 32'd16777);
        end
        1: begin
          write_reg(CfgTimeStep, $urandom_range(1, 32'h3FFFFFFF));
          write_reg(CfgCosPitchMin, $urandom());
        end
        2: begin
          write_reg(CfgTimeStep, 32'hFFFFFFFF);
          write_reg(CfgCosPitchMin, $urandom_range(0, 32'h01000000));
        end
        default: begin
          write_reg(CfgTimeStep, $urandom_range(1, 32'h00400000));
          write_reg(CfgCosPitchMin, $urandom_range(0, 2000000));
        end
      endcase
      random_ticks(200);
      drain();
    end

    if (attitude_sb.failures == 0 && attitude_sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
